[design/dertlv_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the DER TLV element parser.
package dertlv_pkg;

	localparam int MAX_LENGTH_OCTETS_DEF = 4;
	localparam logic [5:0] EXPECTED_TAG_RST = 6'd48;

	typedef enum logic [1:0] {
		REG_EXPECTED_TAG     = 2'd0,
		REG_CHECK_TAG        = 2'd1,
		REG_ALLOW_INDEFINITE = 2'd2,
		REG_DECODE_INTEGER   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_CONTENT = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_TAG_MISMATCH = 3'd1,
		ERR_LEN_OCTETS   = 3'd2,
		ERR_INDEF        = 3'd3,
		ERR_HDR_TRUNC    = 3'd4,
		ERR_CONT_TRUNC   = 3'd5,
		ERR_BAD_INT_LEN  = 3'd6
	} err_t;

	typedef enum logic [3:0] {
		PH_TAG       = 4'b0001,
		PH_LEN_FIRST = 4'b0010,
		PH_LEN_LONG  = 4'b0100,
		PH_CONTENT   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       buffer_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         tag_byte;
		logic [31:0]        content_length;
		logic               definite;
		logic [7:0]         content_byte;
		logic               content_last;
		logic signed [31:0] int_value;
		logic               int_valid;
		logic [2:0]         error_code;
	} out_item_t;

	typedef struct packed {
		logic [5:0] expected_tag;
		logic       check_tag;
		logic       allow_indefinite;
		logic       decode_integer;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  tag_reg;
		logic [2:0]  length_octets_left;
		logic [31:0] length_accum;
		logic [31:0] content_left;
		logic [31:0] int_accum;
	} parse_state_t;

endpackage

[design/dertlv_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file of the DER TLV element parser.
module dertlv_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [5:0]            cfg_data,
	output dertlv_pkg::cfg_t      cfg
);
	import dertlv_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_tag     <= EXPECTED_TAG_RST;
			cfg_q.check_tag        <= 1'b1;
			cfg_q.allow_indefinite <= 1'b0;
			cfg_q.decode_integer   <= 1'b0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_EXPECTED_TAG:     cfg_q.expected_tag     <= cfg_data;
				REG_CHECK_TAG:        cfg_q.check_tag        <= cfg_data[0];
				REG_ALLOW_INDEFINITE: cfg_q.allow_indefinite <= cfg_data[0];
				REG_DECODE_INTEGER:   cfg_q.decode_integer   <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[design/dertlv_step.sv]
`timescale 1ns / 1ps
// Per-octet parse logic: next state and optional result for one octet.
module dertlv_step #(
	parameter int MAX_LENGTH_OCTETS = dertlv_pkg::MAX_LENGTH_OCTETS_DEF
) (
	input  dertlv_pkg::cfg_t         cfg,
	input  dertlv_pkg::parse_state_t st,
	input  dertlv_pkg::in_item_t     item,
	output dertlv_pkg::parse_state_t nxt,
	output logic                     emit,
	output dertlv_pkg::out_item_t    res
);
	import dertlv_pkg::*;

	localparam logic [6:0] MaxOct = 7'(MAX_LENGTH_OCTETS);

	logic [7:0]  b;
	logic        last;
	logic [31:0] acc_sh;
	logic [31:0] int_sh;
	logic [31:0] cnt_dec;
	logic [31:0] int_ext;
	logic        fin;
	logic [31:0] fin_len;
	logic        fin_def;
	logic        len_ok4;
	err_t        err;

	assign b    = item.in_byte;
	assign last = item.buffer_last;
	assign acc_sh  = {st.length_accum[23:0], b};
	assign int_sh  = {st.int_accum[23:0], b};
	assign cnt_dec = st.content_left - 32'd1;
	assign len_ok4 = (st.length_accum != 32'd0) && (st.length_accum <= 32'd4);

	always_comb begin
		case (st.length_accum[2:0])
			3'd1:    int_ext = {{24{int_sh[7]}}, int_sh[7:0]};
			3'd2:    int_ext = {{16{int_sh[15]}}, int_sh[15:0]};
			3'd3:    int_ext = {{8{int_sh[23]}}, int_sh[23:0]};
			default: int_ext = int_sh;
		endcase
	end

	always_comb begin
		nxt     = st;
		emit    = 1'b0;
		res     = '0;
		err     = ERR_NONE;
		fin     = 1'b0;
		fin_len = '0;
		fin_def = 1'b0;

		case (st.phase)
			PH_TAG: begin
				nxt.tag_reg = b;
				if (cfg.check_tag && (b[5:0] != cfg.expected_tag))
					err = ERR_TAG_MISMATCH;
				else if (last)
					err = ERR_HDR_TRUNC;
				else
					nxt.phase = PH_LEN_FIRST;
			end
			PH_LEN_FIRST: begin
				if (b[7]) begin
					if (b[6:0] > MaxOct)
						err = ERR_LEN_OCTETS;
					else if (b[6:0] == 7'd0) begin
						if (!cfg.allow_indefinite)
							err = ERR_INDEF;
						else
							fin = 1'b1;
					end else if (last)
						err = ERR_HDR_TRUNC;
					else begin
						nxt.length_octets_left = b[2:0];
						nxt.length_accum       = '0;
						nxt.phase              = PH_LEN_LONG;
					end
				end else begin
					fin     = 1'b1;
					fin_len = {24'd0, b};
					fin_def = 1'b1;
				end
			end
			PH_LEN_LONG: begin
				nxt.length_accum       = acc_sh;
				nxt.length_octets_left = st.length_octets_left - 3'd1;
				if (st.length_octets_left == 3'd1) begin
					fin     = 1'b1;
					fin_len = acc_sh;
					fin_def = 1'b1;
				end else if (last)
					err = ERR_HDR_TRUNC;
			end
			PH_CONTENT: begin
				nxt.int_accum    = int_sh;
				nxt.content_left = cnt_dec;
				if ((cnt_dec != 32'd0) && last)
					err = ERR_CONT_TRUNC;
				else begin
					emit               = 1'b1;
					res.kind           = KIND_CONTENT;
					res.tag_byte       = st.tag_reg;
					res.content_length = st.length_accum;
					res.definite       = 1'b1;
					res.content_byte   = b;
					if (cnt_dec == 32'd0) begin
						res.content_last = 1'b1;
						nxt.phase        = PH_TAG;
						if (cfg.decode_integer && len_ok4) begin
							res.int_value = int_ext;
							res.int_valid = 1'b1;
						end
					end
				end
			end
			default: nxt.phase = PH_TAG;
		endcase

		if (fin) begin
			if (cfg.decode_integer && ((fin_len == 32'd0) || (fin_len > 32'd4)))
				err = ERR_BAD_INT_LEN;
			else if (last && (fin_len != 32'd0))
				err = ERR_CONT_TRUNC;
			else begin
				emit               = 1'b1;
				res.kind           = KIND_HEADER;
				res.tag_byte       = st.tag_reg;
				res.content_length = fin_len;
				res.definite       = fin_def;
				nxt.length_accum   = fin_len;
				nxt.content_left   = fin_len;
				nxt.int_accum      = '0;
				nxt.phase          = (fin_len == 32'd0) ? PH_TAG : PH_CONTENT;
			end
		end

		if (err != ERR_NONE) begin
			emit           = 1'b1;
			res            = '0;
			res.kind       = KIND_ERROR;
			res.tag_byte   = nxt.tag_reg;
			res.error_code = err;
			nxt.phase      = PH_TAG;
		end
	end

endmodule

[design/der_tlv_element_parser.sv]
`timescale 1ns / 1ps
// Top level of the DER TLV element parser.
// Parses an ASN.1 DER stream one octet per beat: tag check, length in short,
// long (up to MAX_LENGTH_OCTETS octets) or indefinite form, then content
// octets, with an optional signed integer decode of 1 to 4 octets. Each input
// beat gives zero or one result beat (header, content octet or error). One
// octet is taken every clock cycle unless an output stall holds the parse
// logic: an input register feeds the combinational parse logic that updates
// the parse state and loads the result register, and the result register
// decouples output stalls. Configuration writes take effect at once and are
// meant to be made while the block is idle.
module der_tlv_element_parser #(
	parameter int MAX_LENGTH_OCTETS = dertlv_pkg::MAX_LENGTH_OCTETS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dertlv_pkg::in_item_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dertlv_pkg::out_item_t  out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [5:0]             cfg_data
);
	import dertlv_pkg::*;

	cfg_t         cfg;
	parse_state_t st_q;
	parse_state_t st_nxt;
	in_item_t     item_s1;
	logic         valid_s1;
	logic         emit;
	out_item_t    res;
	out_item_t    out_q;
	logic         out_valid_q;
	logic         step;

	dertlv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dertlv_step #(
		.MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
	) u_step (
		.cfg  (cfg),
		.st   (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.emit (emit),
		.res  (res)
	);

	assign step      = valid_s1 && (!out_valid_q || out_ready || !emit);
	assign in_ready  = !valid_s1 || step;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1                <= 1'b0;
			out_valid_q             <= 1'b0;
			st_q.phase              <= PH_TAG;
			st_q.tag_reg            <= '0;
			st_q.length_octets_left <= '0;
			st_q.length_accum       <= '0;
			st_q.content_left       <= '0;
			st_q.int_accum          <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (step) begin
				st_q <= st_nxt;
			end
			if (step && emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
		if (step && emit)
			out_q <= res;
	end

endmodule

[verif/der_tlv_checker.sv]
`timescale 1ns / 1ps
// Checker for the DER TLV parser: tracks the parse, predicts result beats, compares them.
module der_tlv_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  dertlv_pkg::in_item_t  in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  dertlv_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [5:0]            cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    header_count,
	output int                    content_count,
	output int                    int_count,
	output int                    error_count
);
	import dertlv_pkg::*;

	localparam int REPORT_CAP = 200;

	cfg_t        cfg;
	phase_t      ph;
	logic [7:0]  tag_q;
	logic [2:0]  len_left;
	logic [31:0] len_acc;
	logic [31:0] cont_left;
	logic [31:0] int_acc;

	out_item_t expected_beats[$];
	out_item_t want;
	out_item_t pred;
	int        reports;
	int        diffs;

	function automatic void raise_error(input err_t code, output out_item_t r);
		r = '0;
		r.kind = KIND_ERROR;
		r.tag_byte = tag_q;
		r.error_code = code;
		ph = PH_TAG;
	endfunction

	function automatic void close_header(input logic [31:0] len, input logic def,
			input logic last, output out_item_t r);
		if (cfg.decode_integer && (len == 0 || len > 4)) begin
			raise_error(ERR_BAD_INT_LEN, r);
		end else if (last && len != 0) begin
			raise_error(ERR_CONT_TRUNC, r);
		end else begin
			r = '0;
			r.kind = KIND_HEADER;
			r.tag_byte = tag_q;
			r.content_length = len;
			r.definite = def;
			len_acc = len;
			cont_left = len;
			int_acc = '0;
			ph = (len == 0) ? PH_TAG : PH_CONTENT;
		end
	endfunction

	// Returns 1 when the octet produces a result beat.
	function automatic bit parse_octet(input in_item_t it, output out_item_t r);
		logic [7:0]  b;
		logic        last;
		logic [31:0] v;
		bit          got;
		b = it.in_byte;
		last = it.buffer_last;
		got = 1'b1;
		r = '0;
		case (ph)
			PH_TAG: begin
				tag_q = b;
				if (cfg.check_tag && b[5:0] != cfg.expected_tag) begin
					raise_error(ERR_TAG_MISMATCH, r);
				end else if (last) begin
					raise_error(ERR_HDR_TRUNC, r);
				end else begin
					ph = PH_LEN_FIRST;
					got = 1'b0;
				end
			end
			PH_LEN_FIRST: begin
				if (!b[7]) begin
					close_header({24'd0, b}, 1'b1, last, r);
				end else if (b[6:0] > MAX_LENGTH_OCTETS_DEF) begin
					raise_error(ERR_LEN_OCTETS, r);
				end else if (b[6:0] == 0) begin
					if (!cfg.allow_indefinite) begin
						raise_error(ERR_INDEF, r);
					end else begin
						close_header(32'd0, 1'b0, last, r);
					end
				end else if (last) begin
					raise_error(ERR_HDR_TRUNC, r);
				end else begin
					len_left = b[2:0];
					len_acc = '0;
					ph = PH_LEN_LONG;
					got = 1'b0;
				end
			end
			PH_LEN_LONG: begin
				len_acc = {len_acc[23:0], b};
				len_left = len_left - 3'd1;
				if (len_left == 0) begin
					close_header(len_acc, 1'b1, last, r);
				end else if (last) begin
					raise_error(ERR_HDR_TRUNC, r);
				end else begin
					got = 1'b0;
				end
			end
			default: begin
				int_acc = {int_acc[23:0], b};
				cont_left = cont_left - 32'd1;
				if (cont_left != 0 && last) begin
					raise_error(ERR_CONT_TRUNC, r);
				end else begin
					r.kind = KIND_CONTENT;
					r.tag_byte = tag_q;
					r.content_length = len_acc;
					r.definite = 1'b1;
					r.content_byte = b;
					if (cont_left == 0) begin
						r.content_last = 1'b1;
						if (cfg.decode_integer && len_acc >= 1 && len_acc <= 4) begin
							if (len_acc == 1)
								v = {{24{int_acc[7]}}, int_acc[7:0]};
							else if (len_acc == 2)
								v = {{16{int_acc[15]}}, int_acc[15:0]};
							else if (len_acc == 3)
								v = {{8{int_acc[23]}}, int_acc[23:0]};
							else
								v = int_acc;
							r.int_value = v;
							r.int_valid = 1'b1;
						end
						ph = PH_TAG;
					end
				end
			end
		endcase
		return got;
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v === act_v)
			return 0;
		if (reports < REPORT_CAP)
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
		reports++;
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.expected_tag = EXPECTED_TAG_RST;
			cfg.check_tag = 1'b1;
			cfg.allow_indefinite = 1'b0;
			cfg.decode_integer = 1'b0;
			ph = PH_TAG;
			tag_q = '0;
			len_left = '0;
			len_acc = '0;
			cont_left = '0;
			int_acc = '0;
			expected_beats.delete();
			reports = 0;
			fail_count = 0;
			pending = 0;
			header_count = 0;
			content_count = 0;
			int_count = 0;
			error_count = 0;
		end else begin
			// drain before predict: a beat leaving now never belongs to the octet entering now
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (reports < REPORT_CAP)
						$display("%0t: result beat with none expected, expected nothing actual %h",
							$time, out_data);
					reports++;
				end else begin
					want = expected_beats.pop_front();
					diffs = 0;
					diffs += field_diff("kind", want.kind, out_data.kind);
					diffs += field_diff("tag_byte", want.tag_byte, out_data.tag_byte);
					diffs += field_diff("content_length", want.content_length,
						out_data.content_length);
					diffs += field_diff("definite", want.definite, out_data.definite);
					diffs += field_diff("content_byte", want.content_byte, out_data.content_byte);
					diffs += field_diff("content_last", want.content_last, out_data.content_last);
					diffs += field_diff("int_value", want.int_value, out_data.int_value);
					diffs += field_diff("int_valid", want.int_valid, out_data.int_valid);
					diffs += field_diff("error_code", want.error_code, out_data.error_code);
					if (diffs != 0)
						fail_count++;
					case (want.kind)
						KIND_HEADER: header_count++;
						KIND_CONTENT: content_count++;
						default: error_count++;
					endcase
					if (want.int_valid)
						int_count++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EXPECTED_TAG: cfg.expected_tag = cfg_data;
					REG_CHECK_TAG: cfg.check_tag = cfg_data[0];
					REG_ALLOW_INDEFINITE: cfg.allow_indefinite = cfg_data[0];
					default: cfg.decode_integer = cfg_data[0];
				endcase
			end
			if (in_valid && in_ready) begin
				if (parse_octet(in_data, pred))
					expected_beats.push_back(pred);
			end
			pending = expected_beats.size();
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for the DER TLV parser: clock, reset, octet stream, register writes, verdict.
module testbench;
	import dertlv_pkg::*;

	localparam int OCTET_TARGET = 1850;
	localparam int SEGMENTS = 12;
	localparam int QUIET_LIMIT = 1000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	int fail_count;
	int pending;
	int header_count;
	int content_count;
	int int_count;
	int error_count;

	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet = 0;
	int unsigned octets_sent = 0;
	cfg_t        cur_cfg;

	der_tlv_element_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	der_tlv_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.header_count  (header_count),
		.content_count (content_count),
		.int_count     (int_count),
		.error_count   (error_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, quiet);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic put_octet(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.in_byte = b;
		in_data.buffer_last = last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		octets_sent++;
		@(negedge clk);
	endtask

	// hold the stream until every result is out and the pipeline is empty
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [5:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		settle();
		write_reg(REG_EXPECTED_TAG, c.expected_tag);
		write_reg(REG_CHECK_TAG, {5'd0, c.check_tag});
		write_reg(REG_ALLOW_INDEFINITE, {5'd0, c.allow_indefinite});
		write_reg(REG_DECODE_INTEGER, {5'd0, c.decode_integer});
		cfg_valid = 1'b0;
		cur_cfg = c;
	endtask

	task automatic random_element();
		logic [7:0]  octs[$];
		logic [7:0]  tagb;
		logic [7:0]  bad_len;
		logic [31:0] len;
		int          sel;
		int          n;
		int          nmin;
		int          body;
		int          cut;
		bit          mark_last;
		bit          huge;
		sel = $urandom_range(99);
		huge = 1'b0;
		if (sel < 5) begin
			n = $urandom_range(1, 6);
			repeat (n) put_octet(8'($urandom_range(255)), $urandom_range(9) == 0);
			return;
		end
		tagb = 8'($urandom_range(255));
		if ($urandom_range(99) < 85)
			tagb[5:0] = cur_cfg.expected_tag;
		octs.push_back(tagb);
		if (sel < 10) begin
			bad_len = 8'($urandom_range(8'h85, 8'hff));
			octs.push_back(bad_len);
		end else if (sel < 17) begin
			octs.push_back(8'h80);
		end else begin
			if (cur_cfg.decode_integer)
				len = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
			else if (sel < 22) begin
				len = $urandom() >> $urandom_range(0, 24);
				huge = 1'b1;
			end else if (sel < 32)
				len = $urandom_range(13, 200);
			else
				len = $urandom_range(0, 12);
			if (len < 128 && $urandom_range(3) != 0) begin
				octs.push_back(len[7:0]);
			end else begin
				nmin = (len >= 32'h0100_0000) ? 4 : (len >= 32'h0001_0000) ? 3 :
					(len >= 32'h0000_0100) ? 2 : 1;
				n = $urandom_range(nmin, 4);
				octs.push_back(8'h80 | n[7:0]);
				for (int i = n - 1; i >= 0; i--)
					octs.push_back(len[8*i +: 8]);
			end
			body = huge ? $urandom_range(0, 6) : len;
			repeat (body) octs.push_back(8'($urandom_range(255)));
		end
		mark_last = huge || ($urandom_range(99) < 25);
		if (!huge && octs.size() > 1 && $urandom_range(99) < 10) begin
			cut = $urandom_range(octs.size() - 1);
			while (octs.size() > cut + 1)
				void'(octs.pop_back());
			mark_last = 1'b1;
		end
		foreach (octs[i])
			put_octet(octs[i], mark_last && i == octs.size() - 1);
	endtask

	initial begin
		cfg_t c;
		int   k;
		cur_cfg.expected_tag = EXPECTED_TAG_RST;
		cur_cfg.check_tag = 1'b1;
		cur_cfg.allow_indefinite = 1'b0;
		cur_cfg.decode_integer = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset register values
		put_octet(8'h30, 0); put_octet(8'h00, 0);
		put_octet(8'hf0, 0); put_octet(8'h01, 0); put_octet(8'hab, 1);
		put_octet(8'h31, 0);
		put_octet(8'h30, 1);
		put_octet(8'h30, 0); put_octet(8'h85, 0);
		put_octet(8'h30, 0); put_octet(8'h80, 0);
		put_octet(8'h30, 0); put_octet(8'h82, 1);
		put_octet(8'h30, 0); put_octet(8'h81, 0); put_octet(8'h05, 1);
		put_octet(8'h30, 0); put_octet(8'h84, 0);
		put_octet(8'hff, 0); put_octet(8'hff, 0); put_octet(8'hff, 0); put_octet(8'hff, 0);
		put_octet(8'h00, 1);

		// directed, integer mode with indefinite form allowed
		c.expected_tag = EXPECTED_TAG_RST;
		c.check_tag = 1'b0;
		c.allow_indefinite = 1'b1;
		c.decode_integer = 1'b1;
		apply_cfg(c);
		put_octet(8'h30, 0); put_octet(8'h80, 0);
		put_octet(8'h02, 0); put_octet(8'h01, 0); put_octet(8'h80, 0);
		put_octet(8'h02, 0); put_octet(8'h04, 0);
		put_octet(8'h7f, 0); put_octet(8'hff, 0); put_octet(8'hff, 0); put_octet(8'hff, 0);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 54; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 54; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			for (int s = 0; s < 3; s++) begin
				k = p * 3 + s;
				c.expected_tag = 6'($urandom_range(63));
				if (k == 0)
					c.expected_tag = 6'd0;
				else if (k == 1)
					c.expected_tag = 6'd63;
				c.check_tag = (k % 4 != 3);
				c.allow_indefinite = k[0];
				c.decode_integer = (k % 3 == 2);
				apply_cfg(c);
				while (octets_sent < (k + 1) * OCTET_TARGET / SEGMENTS)
					random_element();
			end
		end

		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d octets under %0d register settings and four idle/stall mixes.",
			octets_sent, SEGMENTS + 2);
		$display("Checked %0d headers, %0d content octets (%0d integers), %0d errors.",
			header_count, content_count, int_count, error_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[der_tlv_element_parser.f]
design/dertlv_pkg.sv
design/dertlv_cfg.sv
design/dertlv_step.sv
design/der_tlv_element_parser.sv
verif/der_tlv_checker.sv
verif/testbench.sv
